[rtl/assert_macros.svh]
// Assertion macros used by the checker file qsu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that a condition never holds, disabled while reset is high.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/qsu_pkg.sv]
// Types and constants of the quoted string unescaper.
package qsu_pkg;

   localparam int unsigned DEF_MAX_FRAME_BYTES = 65535;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_CLOSE  = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [3:0] PH_AWAIT    = 4'd0;
   localparam logic [3:0] PH_BODY     = 4'd1;
   localparam logic [3:0] PH_ESC      = 4'd2;
   localparam logic [3:0] PH_HEX_HIGH = 4'd3;
   localparam logic [3:0] PH_NEED_BSL = 4'd4;
   localparam logic [3:0] PH_NEED_U   = 4'd5;
   localparam logic [3:0] PH_HEX_LOW  = 4'd6;
   localparam logic [3:0] PH_SQ_SEEN  = 4'd7;
   localparam logic [3:0] PH_DONE     = 4'd8;

   typedef struct packed {
      logic [3:0]  phase;
      logic        dq;
      logic [15:0] acc;
      logic [1:0]  hcnt;
      logic [9:0]  hs;
      logic [15:0] bcount;
   } qsu_state_type;

   localparam qsu_state_type STATE_RESET = '{
      phase: PH_AWAIT, dq: 1'b0, acc: 16'h0, hcnt: 2'd0, hs: 10'h0, bcount: 16'h0};

   // Results caused by one input transaction: data bytes first, then the status.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      n_data;
      logic            has_status;
      logic [1:0]      status_kind;
      logic [15:0]     consumed;
   } qsu_bundle_type;

endpackage

[rtl/qsu_decode.sv]
// Per-byte decode: next parse state and the results one byte causes.
module qsu_decode import qsu_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  qsu_state_type  cur,
   input  logic [7:0]     in_byte,
   input  logic           frame_last,
   output qsu_state_type  nxt,
   output qsu_bundle_type bnd
);

   localparam logic [15:0] COUNT_LIMIT =
      16'((MAX_FRAME_BYTES < 65535) ? MAX_FRAME_BYTES : 65535);

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_U      = 8'h75;

   logic [15:0]     bc_inc;
   logic [3:0]      hv;
   logic            hok;
   logic [15:0]     acc_new;
   logic            hex_done;
   logic            is_hi;
   logic            is_lo;
   logic [20:0]     cp;
   logic [3:0][7:0] enc;
   logic [2:0]      enc_n;

   assign bc_inc = (cur.bcount < COUNT_LIMIT) ? cur.bcount + 16'd1 : cur.bcount;

   always_comb begin
      hv  = 4'(in_byte[3:0] + 4'd9);
      hok = 1'b0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hv  = in_byte[3:0];
         hok = 1'b1;
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         hok = 1'b1;
      end
   end

   assign acc_new  = {cur.acc[11:0], hv};
   assign hex_done = (cur.hcnt == 2'd3);
   assign is_hi    = (acc_new >= 16'hD800) && (acc_new <= 16'hDBFF);
   assign is_lo    = (acc_new >= 16'hDC00) && (acc_new <= 16'hDFFF);
   assign cp       = (cur.phase == PH_HEX_LOW) ?
                     21'h10000 + {1'b0, cur.hs, acc_new[9:0]} : {5'd0, acc_new};

   always_comb begin
      enc = '0;
      if (cp < 21'h80) begin
         enc[0] = cp[7:0];
         enc_n  = 3'd1;
      end else if (cp < 21'h800) begin
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
         enc_n  = 3'd2;
      end else if (cp < 21'h10000) begin
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
         enc_n  = 3'd3;
      end else begin
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
         enc_n  = 3'd4;
      end
   end

   always_comb begin
      nxt = cur;
      bnd = '0;
      unique case (cur.phase)
         PH_AWAIT: begin
            if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
               nxt.dq     = (in_byte == CH_DQUOTE);
               nxt.bcount = 16'd1;
               nxt.phase  = PH_BODY;
            end else begin
               bnd.has_status  = 1'b1;
               bnd.status_kind = KIND_REJECT;
               nxt.phase       = PH_DONE;
            end
         end
         PH_BODY: begin
            nxt.bcount = bc_inc;
            if (in_byte == (cur.dq ? CH_DQUOTE : CH_SQUOTE)) begin
               if (cur.dq) begin
                  bnd.has_status  = 1'b1;
                  bnd.status_kind = KIND_CLOSE;
                  bnd.consumed    = bc_inc;
                  nxt.phase       = PH_DONE;
               end else begin
                  nxt.phase = PH_SQ_SEEN;
               end
            end else if (cur.dq && in_byte == CH_BSL) begin
               nxt.phase = PH_ESC;
            end else if (in_byte < CH_SPACE && in_byte != CH_TAB) begin
               bnd.has_status  = 1'b1;
               bnd.status_kind = KIND_REJECT;
               nxt.phase       = PH_DONE;
            end else begin
               bnd.data[0] = in_byte;
               bnd.n_data  = 3'd1;
            end
         end
         PH_SQ_SEEN: begin
            if (in_byte == CH_SQUOTE) begin
               nxt.bcount  = bc_inc;
               bnd.data[0] = CH_SQUOTE;
               bnd.n_data  = 3'd1;
               nxt.phase   = PH_BODY;
            end else begin
               bnd.has_status  = 1'b1;
               bnd.status_kind = KIND_CLOSE;
               bnd.consumed    = cur.bcount;
               nxt.phase       = PH_DONE;
            end
         end
         PH_ESC: begin
            nxt.bcount = bc_inc;
            nxt.phase  = PH_BODY;
            bnd.n_data = 3'd1;
            unique case (in_byte)
               CH_B:      bnd.data[0] = 8'h08;
               CH_T:      bnd.data[0] = 8'h09;
               CH_N:      bnd.data[0] = 8'h0A;
               CH_F:      bnd.data[0] = 8'h0C;
               CH_R:      bnd.data[0] = 8'h0D;
               CH_DQUOTE: bnd.data[0] = CH_DQUOTE;
               CH_SLASH:  bnd.data[0] = CH_SLASH;
               CH_BSL:    bnd.data[0] = CH_BSL;
               CH_U: begin
                  bnd.n_data = 3'd0;
                  nxt.acc    = 16'h0;
                  nxt.hcnt   = 2'd0;
                  nxt.phase  = PH_HEX_HIGH;
               end
               default: begin
                  bnd.n_data      = 3'd0;
                  bnd.has_status  = 1'b1;
                  bnd.status_kind = KIND_REJECT;
                  nxt.phase       = PH_DONE;
               end
            endcase
         end
         PH_HEX_HIGH, PH_HEX_LOW: begin
            nxt.bcount = bc_inc;
            if (!hok) begin
               bnd.has_status  = 1'b1;
               bnd.status_kind = KIND_REJECT;
               nxt.phase       = PH_DONE;
            end else begin
               nxt.acc = acc_new;
               if (!hex_done) begin
                  nxt.hcnt = cur.hcnt + 2'd1;
               end else if (cur.phase == PH_HEX_HIGH && is_hi) begin
                  nxt.hs    = acc_new[9:0];
                  nxt.phase = PH_NEED_BSL;
               end else if ((cur.phase == PH_HEX_HIGH && is_lo) ||
                            (cur.phase == PH_HEX_LOW && !is_lo)) begin
                  bnd.has_status  = 1'b1;
                  bnd.status_kind = KIND_REJECT;
                  nxt.phase       = PH_DONE;
               end else begin
                  bnd.data   = enc;
                  bnd.n_data = enc_n;
                  nxt.phase  = PH_BODY;
               end
            end
         end
         PH_NEED_BSL: begin
            nxt.bcount = bc_inc;
            if (in_byte == CH_BSL) begin
               nxt.phase = PH_NEED_U;
            end else begin
               bnd.has_status  = 1'b1;
               bnd.status_kind = KIND_REJECT;
               nxt.phase       = PH_DONE;
            end
         end
         PH_NEED_U: begin
            nxt.bcount = bc_inc;
            if (in_byte == CH_U) begin
               nxt.acc   = 16'h0;
               nxt.hcnt  = 2'd0;
               nxt.phase = PH_HEX_LOW;
            end else begin
               bnd.has_status  = 1'b1;
               bnd.status_kind = KIND_REJECT;
               nxt.phase       = PH_DONE;
            end
         end
         default: begin
            nxt.phase = PH_DONE;
         end
      endcase

      if (frame_last) begin
         if (nxt.phase == PH_SQ_SEEN) begin
            bnd.has_status  = 1'b1;
            bnd.status_kind = KIND_CLOSE;
            bnd.consumed    = nxt.bcount;
         end else if (nxt.phase != PH_DONE) begin
            bnd.has_status  = 1'b1;
            bnd.status_kind = KIND_REJECT;
            bnd.consumed    = 16'h0;
         end
         nxt = STATE_RESET;
      end
   end

endmodule

[rtl/quoted_string_unescape_core.sv]
// Quoted string unescaper top level: parse state, result buffer and output register.
// Takes one source byte per transaction and decodes it combinationally. A byte that
// causes at most one result is taken every cycle while rsp_stall is low. A byte that
// completes a \u escape causes up to four UTF-8 data bytes, plus a status on the
// frame's final byte; results leave through the single output register one per cycle
// while rsp_stall is low, so such a byte holds req_stall high until its last result
// moves to the output register. The first result of a byte passes through the result
// buffer and the output register to the rsp_ ports. Each frame ends with exactly
// one status transaction (rsp_last high): closed with the consumed byte count, or
// rejected, in which case the data bytes of that frame are to be discarded.
module quoted_string_unescape_core import qsu_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_consumed,
   output logic        rsp_last
);

   qsu_state_type  state_ff, state_in;
   qsu_bundle_type bnd_ff, bnd_in;
   logic [2:0]     rem_ff;
   logic [2:0]     idx_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_kind_ff;
   logic [7:0]     rsp_out_byte_ff;
   logic [15:0]    rsp_consumed_ff;
   logic           req_take;
   logic           move;
   logic           is_data;

   qsu_decode #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_decode (
      .cur        (state_ff),
      .in_byte    (req_in_byte),
      .frame_last (req_frame_last),
      .nxt        (state_in),
      .bnd        (bnd_in)
   );

   assign move      = (rem_ff != 3'd0) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((rem_ff == 3'd0) || (rem_ff == 3'd1 && move));
   assign req_take  = req_valid && !req_stall;
   assign is_data   = (idx_ff < bnd_ff.n_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         rem_ff   <= 3'd0;
         idx_ff   <= 3'd0;
      end else if (req_take) begin
         state_ff <= state_in;
         rem_ff   <= bnd_in.n_data + {2'd0, bnd_in.has_status};
         idx_ff   <= 3'd0;
      end else if (move) begin
         rem_ff <= rem_ff - 3'd1;
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         bnd_ff <= bnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         if (is_data) begin
            rsp_kind_ff     <= KIND_DATA;
            rsp_out_byte_ff <= bnd_ff.data[idx_ff[1:0]];
            rsp_consumed_ff <= 16'h0;
         end else begin
            rsp_kind_ff     <= bnd_ff.status_kind;
            rsp_out_byte_ff <= 8'h0;
            rsp_consumed_ff <= bnd_ff.consumed;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_consumed = rsp_consumed_ff;
   assign rsp_last     = (rsp_kind_ff != KIND_DATA);

endmodule

[rtl/qsu_checker.sv]
// Port-level assertions for the quoted string unescaper, bound to the top level.
`include "assert_macros.svh"

module qsu_checker import qsu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_in_byte,
   input logic        req_frame_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [15:0] rsp_consumed,
   input logic        rsp_last
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_consumed), "stalled result transaction changed")
   `ASSERT_CLK(a_data_shape, clock, reset, rsp_valid && rsp_kind == KIND_DATA |-> !rsp_last && rsp_consumed == 16'h0, "data transaction carries status fields")
   `ASSERT_CLK(a_status_shape, clock, reset, rsp_valid && rsp_kind != KIND_DATA |-> rsp_last && rsp_out_byte == 8'h0, "status transaction carries a data byte")
   `ASSERT_NEVER(a_reject_count, clock, reset, rsp_valid && rsp_kind == KIND_REJECT && rsp_consumed != 16'h0, "reject transaction carries a byte count")

endmodule

bind quoted_string_unescape_core qsu_checker u_qsu_checker (.*);

[verif/quoted_string_unescape_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for quoted_string_unescape_core: directed table, random frames.
module quoted_string_unescape_core_tb;
   import qsu_pkg::*;

   localparam int unsigned COUNT_LIMIT =
      (DEF_MAX_FRAME_BYTES < 65535) ? DEF_MAX_FRAME_BYTES : 65535;

   localparam logic [7:0] DQUOTE   = 8'h22;
   localparam logic [7:0] SQUOTE   = 8'h27;
   localparam logic [7:0] BSLASH   = 8'h5C;
   localparam logic [7:0] TAB      = 8'h09;
   localparam logic [7:0] LETTER_U = 8'h75;

   localparam int RANDOM_ITEMS_PER_PHASE = 110;
   localparam int IDLE_PCT [4]  = '{0, 79, 0, 8};
   localparam int STALL_PCT [4] = '{0, 0, 79, 8};

   localparam logic [7:0] ESCAPE_LETTERS [8] = '{"b", "t", "n", "f", "r", DQUOTE, "/", BSLASH};

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [15:0] consumed;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [7:0]  in_byte;
      logic        frame_last;
      logic        typed;
      logic [1:0]  kind;
      logic [15:0] consumed;
   } stim_row_type;

   // typed rows carry their single status transaction; the rest go through the predictor
   localparam stim_row_type DIRECTED_ROWS [0:23] = '{
      '{8'h00,    1'b0, 1'b1, KIND_REJECT, 16'd0},
      '{8'hFF,    1'b1, 1'b0, KIND_DATA,   16'd0},
      '{DQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{BSLASH,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{"b",      1'b0, 1'b0, KIND_DATA,   16'd0},
      '{BSLASH,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{"x",      1'b0, 1'b1, KIND_REJECT, 16'd0},
      '{DQUOTE,   1'b1, 1'b0, KIND_DATA,   16'd0},
      '{SQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{SQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{SQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{8'hFF,    1'b0, 1'b0, KIND_DATA,   16'd0},
      '{8'h01,    1'b0, 1'b1, KIND_REJECT, 16'd0},
      '{8'h00,    1'b1, 1'b0, KIND_DATA,   16'd0},
      '{SQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{TAB,      1'b0, 1'b0, KIND_DATA,   16'd0},
      '{SQUOTE,   1'b1, 1'b1, KIND_CLOSE,  16'd3},
      '{SQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{SQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{"A",      1'b0, 1'b1, KIND_CLOSE,  16'd2},
      '{"A",      1'b1, 1'b0, KIND_DATA,   16'd0},
      '{DQUOTE,   1'b0, 1'b0, KIND_DATA,   16'd0},
      '{8'h7F,    1'b1, 1'b0, KIND_DATA,   16'd0},
      '{DQUOTE,   1'b1, 1'b1, KIND_REJECT, 16'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_frame_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_consumed;
   logic        rsp_last;

   // predictor state
   logic [3:0]  ph;
   logic        dq;
   logic [15:0] acc;
   logic [1:0]  hcnt;
   logic [9:0]  hs;
   logic [15:0] bcount;

   result_type step_results[$];
   result_type awaited_results[$];
   logic [7:0] frame_bytes[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;

   quoted_string_unescape_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_frame_last (req_frame_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_consumed   (rsp_consumed),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void clear_state();
      ph = PH_AWAIT;
      dq = 1'b0;
      acc = '0;
      hcnt = '0;
      hs = '0;
      bcount = '0;
   endfunction

   function automatic void put_result(logic [1:0] k, logic [7:0] b, logic [15:0] n);
      result_type r;
      if (step_results.size() >= 5) return;
      r.kind = k;
      r.out_byte = b;
      r.consumed = n;
      r.last = (k != KIND_DATA);
      step_results.push_back(r);
   endfunction

   function automatic void reject_frame();
      put_result(KIND_REJECT, 8'h00, 16'h0000);
      ph = PH_DONE;
   endfunction

   function automatic void count_byte();
      if (bcount < COUNT_LIMIT) bcount++;
   endfunction

   function automatic void emit_utf8(int unsigned cp);
      if (cp < 'h80) begin
         put_result(KIND_DATA, 8'(cp), 16'h0000);
      end else if (cp < 'h800) begin
         put_result(KIND_DATA, 8'hC0 | 8'(cp >> 6), 16'h0000);
         put_result(KIND_DATA, 8'h80 | 8'(cp & 'h3F), 16'h0000);
      end else if (cp < 'h10000) begin
         put_result(KIND_DATA, 8'hE0 | 8'(cp >> 12), 16'h0000);
         put_result(KIND_DATA, 8'h80 | 8'((cp >> 6) & 'h3F), 16'h0000);
         put_result(KIND_DATA, 8'h80 | 8'(cp & 'h3F), 16'h0000);
      end else begin
         put_result(KIND_DATA, 8'hF0 | 8'((cp >> 18) & 'h07), 16'h0000);
         put_result(KIND_DATA, 8'h80 | 8'((cp >> 12) & 'h3F), 16'h0000);
         put_result(KIND_DATA, 8'h80 | 8'((cp >> 6) & 'h3F), 16'h0000);
         put_result(KIND_DATA, 8'h80 | 8'(cp & 'h3F), 16'h0000);
      end
   endfunction

   function automatic int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // 1 when the fourth digit lands, 0 while collecting, -1 on a bad digit
   function automatic int hex_take(logic [7:0] c);
      int v;
      v = hex_val(c);
      if (v < 0) return -1;
      acc = {acc[11:0], 4'(v)};
      if (hcnt >= 2'd3) return 1;
      hcnt++;
      return 0;
   endfunction

   function automatic void unescape_byte(logic [7:0] c, logic fin);
      int h;
      step_results.delete();
      case (ph)
         PH_AWAIT: begin
            if (c == DQUOTE || c == SQUOTE) begin
               dq = (c == DQUOTE);
               bcount = '0;
               count_byte();
               ph = PH_BODY;
            end else begin
               reject_frame();
            end
         end
         PH_BODY: begin
            count_byte();
            if (c == (dq ? DQUOTE : SQUOTE)) begin
               if (dq) begin
                  put_result(KIND_CLOSE, 8'h00, bcount);
                  ph = PH_DONE;
               end else begin
                  ph = PH_SQ_SEEN;
               end
            end else if (dq && c == BSLASH) begin
               ph = PH_ESC;
            end else if (c < 8'h20 && c != TAB) begin
               reject_frame();
            end else begin
               put_result(KIND_DATA, c, 16'h0000);
            end
         end
         PH_SQ_SEEN: begin
            if (c == SQUOTE) begin
               count_byte();
               put_result(KIND_DATA, SQUOTE, 16'h0000);
               ph = PH_BODY;
            end else begin
               put_result(KIND_CLOSE, 8'h00, bcount);
               ph = PH_DONE;
            end
         end
         PH_ESC: begin
            count_byte();
            ph = PH_BODY;
            case (c)
               "b": put_result(KIND_DATA, 8'h08, 16'h0000);
               "t": put_result(KIND_DATA, 8'h09, 16'h0000);
               "n": put_result(KIND_DATA, 8'h0A, 16'h0000);
               "f": put_result(KIND_DATA, 8'h0C, 16'h0000);
               "r": put_result(KIND_DATA, 8'h0D, 16'h0000);
               DQUOTE: put_result(KIND_DATA, DQUOTE, 16'h0000);
               "/": put_result(KIND_DATA, "/", 16'h0000);
               BSLASH: put_result(KIND_DATA, BSLASH, 16'h0000);
               LETTER_U: begin
                  acc = '0;
                  hcnt = '0;
                  ph = PH_HEX_HIGH;
               end
               default: reject_frame();
            endcase
         end
         PH_HEX_HIGH: begin
            count_byte();
            h = hex_take(c);
            if (h < 0) begin
               reject_frame();
            end else if (h > 0) begin
               if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                  hs = 10'(acc - 16'hD800);
                  ph = PH_NEED_BSL;
               end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                  reject_frame();
               end else begin
                  emit_utf8(acc);
                  ph = PH_BODY;
               end
            end
         end
         PH_NEED_BSL: begin
            count_byte();
            if (c == BSLASH) ph = PH_NEED_U;
            else reject_frame();
         end
         PH_NEED_U: begin
            count_byte();
            if (c == LETTER_U) begin
               acc = '0;
               hcnt = '0;
               ph = PH_HEX_LOW;
            end else begin
               reject_frame();
            end
         end
         PH_HEX_LOW: begin
            count_byte();
            h = hex_take(c);
            if (h < 0) begin
               reject_frame();
            end else if (h > 0) begin
               if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                  emit_utf8(32'h10000 + (32'(hs) << 10) + 32'(acc - 16'hDC00));
                  ph = PH_BODY;
               end else begin
                  reject_frame();
               end
            end
         end
         default: ph = PH_DONE;
      endcase
      if (fin) begin
         if (ph == PH_SQ_SEEN) put_result(KIND_CLOSE, 8'h00, bcount);
         else if (ph != PH_DONE) put_result(KIND_REJECT, 8'h00, 16'h0000);
         clear_state();
      end
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      logic [7:0] ch;
      if (v < 4'd10) return 8'h30 + 8'(v);
      ch = 8'h61 + 8'(v) - 8'd10;
      if ($urandom_range(1) == 1) ch = ch - 8'h20;
      return ch;
   endfunction

   function automatic void push_escape_u(logic [15:0] v);
      frame_bytes.push_back(BSLASH);
      frame_bytes.push_back(LETTER_U);
      frame_bytes.push_back(hex_char(v[15:12]));
      frame_bytes.push_back(hex_char(v[11:8]));
      frame_bytes.push_back(hex_char(v[7:4]));
      frame_bytes.push_back(hex_char(v[3:0]));
   endfunction

   function automatic logic [7:0] plain_char(bit in_double);
      logic [7:0] ch;
      if ($urandom_range(9) == 0) return TAB;
      do ch = 8'($urandom_range(255, 32));
      while (ch == (in_double ? DQUOTE : SQUOTE) || (in_double && ch == BSLASH));
      return ch;
   endfunction

   function automatic logic [15:0] random_bmp();
      logic [15:0] v;
      case ($urandom_range(2))
         0: v = 16'($urandom_range('h7F));
         1: v = 16'($urandom_range('h7FF, 'h80));
         default: begin
            do v = 16'($urandom_range('hFFFF, 'h800));
            while (v >= 16'hD800 && v <= 16'hDFFF);
         end
      endcase
      return v;
   endfunction

   function automatic logic [15:0] random_high();
      return 16'($urandom_range('hDBFF, 'hD800));
   endfunction

   function automatic logic [15:0] random_low();
      return 16'($urandom_range('hDFFF, 'hDC00));
   endfunction

   function automatic void build_double_frame();
      int sel;
      frame_bytes.push_back(DQUOTE);
      repeat ($urandom_range(6)) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            frame_bytes.push_back(plain_char(1'b1));
         end else if (sel < 60) begin
            frame_bytes.push_back(BSLASH);
            frame_bytes.push_back(ESCAPE_LETTERS[$urandom_range(7)]);
         end else if (sel < 78) begin
            push_escape_u(random_bmp());
         end else if (sel < 93) begin
            push_escape_u(random_high());
            push_escape_u(random_low());
         end else begin
            // broken surrogate shapes
            case ($urandom_range(4))
               0: push_escape_u(random_low());
               1: begin
                  push_escape_u(random_high());
                  frame_bytes.push_back(plain_char(1'b1));
               end
               2: begin
                  push_escape_u(random_high());
                  frame_bytes.push_back(BSLASH);
                  frame_bytes.push_back(ESCAPE_LETTERS[$urandom_range(7)]);
               end
               3: begin
                  push_escape_u(random_high());
                  push_escape_u(random_high());
               end
               default: begin
                  push_escape_u(random_high());
                  push_escape_u(random_bmp());
               end
            endcase
         end
      end
      frame_bytes.push_back(DQUOTE);
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(2, 1)) frame_bytes.push_back(8'($urandom));
      end
   endfunction

   function automatic void build_single_frame();
      frame_bytes.push_back(SQUOTE);
      repeat ($urandom_range(6)) begin
         if ($urandom_range(4) == 0) begin
            frame_bytes.push_back(SQUOTE);
            frame_bytes.push_back(SQUOTE);
         end else begin
            frame_bytes.push_back(plain_char(1'b0));
         end
      end
      frame_bytes.push_back(SQUOTE);
      if ($urandom_range(1) == 1) begin
         repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom));
      end
   endfunction

   function automatic void build_random_frame();
      int sel;
      frame_bytes.delete();
      sel = $urandom_range(99);
      if (sel < 65) begin
         build_double_frame();
      end else if (sel < 85) begin
         build_single_frame();
      end else begin
         if ($urandom_range(1) == 1) build_double_frame();
         else build_single_frame();
         case ($urandom_range(2))
            0: frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom);
            1: repeat ($urandom_range(frame_bytes.size() - 1, 1)) void'(frame_bytes.pop_back());
            default: begin
               frame_bytes.delete();
               repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom));
            end
         endcase
      end
   endfunction

   task automatic send_byte(logic [7:0] c, logic fin, bit predicted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= c;
      req_frame_last <= fin;
      do @(posedge clock);
      while (req_stall);
      unescape_byte(c, fin);
      if (predicted) begin
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (awaited_results.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_kind, rsp_out_byte, rsp_consumed, rsp_last};
         if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected transaction: kind %0d byte %02h consumed %0d last %0b",
                        seen.kind, seen.out_byte, seen.consumed, seen.last);
            end
         end else begin
            want = awaited_results.pop_front();
            if (seen.kind !== want.kind || seen.out_byte !== want.out_byte ||
                seen.consumed !== want.consumed || seen.last !== want.last) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: expected kind %0d byte %02h consumed %0d last %0b, %s",
                           want.kind, want.out_byte, want.consumed, want.last, "got:");
                  $display("          kind %0d byte %02h consumed %0d last %0b",
                           seen.kind, seen.out_byte, seen.consumed, seen.last);
               end
            end
         end
      end
   end

   initial begin
      int         sent;
      result_type status;
      clear_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++) begin
         send_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].frame_last,
                   !DIRECTED_ROWS[i].typed);
         if (DIRECTED_ROWS[i].typed) begin
            status.kind = DIRECTED_ROWS[i].kind;
            status.out_byte = 8'h00;
            status.consumed = DIRECTED_ROWS[i].consumed;
            status.last = 1'b1;
            awaited_results.push_back(status);
         end
      end
      drain_results();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = IDLE_PCT[p];
         stall_pct = STALL_PCT[p];
         sent = 0;
         while (sent < RANDOM_ITEMS_PER_PHASE) begin
            build_random_frame();
            send_frame();
            sent += frame_bytes.size();
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
